// ===== sv/srsw_pkg.sv =====
// shared types, codes and constants of the selective-repeat sender window
`default_nettype none

package srsw_pkg;

  // fixed field widths
  localparam int SEQ_W       = 4;
  localparam int PAYLOAD_W   = 64;
  localparam int CMD_W       = 2;
  localparam int SPACE_REG_W = 5;
  localparam int WIN_REG_W   = 4;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  localparam int DEF_MAX_SEQ_SPACE = 16;

  // register reset values
  localparam logic [SPACE_REG_W-1:0] SEQ_SPACE_RST = 5'd8;
  localparam logic [WIN_REG_W-1:0]   WINDOW_RST    = 4'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_SPACE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  // operations of the shared modular unit
  typedef enum logic {
    OP_DIST = 1'b0,
    OP_INC  = 1'b1
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     seq_num;
    logic                 ack_check_ok;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 transmit;
    logic [SEQ_W-1:0]     tx_seq;
    logic [PAYLOAD_W-1:0] tx_payload;
    logic                 timer_stop;
    logic                 timer_start;
    logic [SEQ_W-1:0]     timer_seq;
    logic                 window_full;
    logic [SEQ_W-1:0]     window_base;
    logic [SEQ_W-1:0]     next_seq;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/srsw_modu.sv =====
// shared modular arithmetic unit: distance from base and wrapping increment
`default_nettype none

module srsw_modu #(
  parameter int MaxSeqSpace = srsw_pkg::DEF_MAX_SEQ_SPACE,
  localparam int IdxW = $clog2(MaxSeqSpace),
  localparam int SpW  = IdxW + 1
) (
  input  wire srsw_pkg::op_e  op_i,
  input  wire [IdxW-1:0]      a_i,
  input  wire [IdxW-1:0]      b_i,
  input  wire [SpW-1:0]       space_i,
  output logic [IdxW-1:0]     res_o
);

  logic [SpW-1:0] a_ext;
  logic [SpW-1:0] b_ext;
  logic [SpW-1:0] sum;

  always_comb begin
    a_ext = {1'b0, a_i};
    b_ext = {1'b0, b_i};
    case (op_i)
      srsw_pkg::OP_DIST: begin
        // (a - b) mod space, both operands already below space
        if (a_ext >= b_ext) begin
          sum = a_ext - b_ext;
        end else begin
          sum = a_ext + space_i - b_ext;
        end
      end
      srsw_pkg::OP_INC: begin
        sum = a_ext + {{(SpW-1){1'b0}}, 1'b1};
        if (sum == space_i) begin
          sum = '0;
        end
      end
      default: begin
        sum = '0;
      end
    endcase
    res_o = sum[IdxW-1:0];
  end

endmodule

`default_nettype wire

// ===== sv/srsw_store.sv =====
// acked marks and stored payloads, one entry per sequence number
`default_nettype none

module srsw_store #(
  parameter int MaxSeqSpace = srsw_pkg::DEF_MAX_SEQ_SPACE,
  localparam int IdxW = $clog2(MaxSeqSpace)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               mark_we_i,
  input  wire [IdxW-1:0]                    mark_idx_i,
  input  wire                               mark_val_i,
  input  wire [IdxW-1:0]                    seq_idx_i,
  input  wire [IdxW-1:0]                    base_idx_i,
  output logic                              mark_seq_o,
  output logic                              mark_base_o,
  input  wire                               mem_we_i,
  input  wire [IdxW-1:0]                    mem_waddr_i,
  input  wire [srsw_pkg::PAYLOAD_W-1:0]     mem_wdata_i,
  input  wire                               mem_re_i,
  input  wire [IdxW-1:0]                    mem_raddr_i,
  output logic [srsw_pkg::PAYLOAD_W-1:0]    mem_rdata_o
);

  logic [MaxSeqSpace-1:0]             marks_q;
  logic [srsw_pkg::PAYLOAD_W-1:0]     mem_q [MaxSeqSpace];
  logic [srsw_pkg::PAYLOAD_W-1:0]     rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else if (mark_we_i) begin
      marks_q[mark_idx_i] <= mark_val_i;
    end
  end

  always_comb begin
    mark_seq_o  = marks_q[seq_idx_i];
    mark_base_o = marks_q[base_idx_i];
  end

  // payload memory, no reset
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_waddr_i] <= mem_wdata_i;
    end
    if (mem_re_i) begin
      rdata_q <= mem_q[mem_raddr_i];
    end
  end

  assign mem_rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/srsw_ctrl.sv =====
// sequencer: window registers, command decode and mark slide
`default_nettype none

module srsw_ctrl #(
  parameter int MaxSeqSpace = srsw_pkg::DEF_MAX_SEQ_SPACE,
  localparam int IdxW = $clog2(MaxSeqSpace),
  localparam int SpW  = IdxW + 1
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire srsw_pkg::in_item_t           in_item_i,
  input  wire [SpW-1:0]                     space_i,
  input  wire [IdxW-1:0]                    win_i,
  input  wire                               cfg_space_we_i,
  input  wire [SpW-1:0]                     cfg_space_i,
  input  wire                               out_free_i,
  output logic                              done_o,
  output srsw_pkg::out_item_t               res_o,
  output srsw_pkg::op_e                     unit_op_o,
  output logic [IdxW-1:0]                   unit_a_o,
  output logic [IdxW-1:0]                   unit_b_o,
  input  wire [IdxW-1:0]                    unit_res_i,
  output logic                              mark_we_o,
  output logic [IdxW-1:0]                   mark_idx_o,
  output logic                              mark_val_o,
  output logic [IdxW-1:0]                   seq_idx_o,
  output logic [IdxW-1:0]                   base_idx_o,
  input  wire                               mark_seq_i,
  input  wire                               mark_base_i,
  output logic                              mem_we_o,
  output logic [IdxW-1:0]                   mem_waddr_o,
  output logic [srsw_pkg::PAYLOAD_W-1:0]    mem_wdata_o,
  output logic                              mem_re_o,
  output logic [IdxW-1:0]                   mem_raddr_o,
  input  wire [srsw_pkg::PAYLOAD_W-1:0]     mem_rdata_i
);

  localparam int SeqW = srsw_pkg::SEQ_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SDIST,
    ST_EXEC,
    ST_SLIDE,
    ST_READ,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [srsw_pkg::CMD_W-1:0]      cmd_q;
  logic [srsw_pkg::PAYLOAD_W-1:0]  payload_q;
  logic [SeqW-1:0]                 seq_q;
  logic                            chk_q;
  logic [IdxW-1:0]                 base_q;
  logic [IdxW-1:0]                 next_q;
  logic                            waiting_q;
  logic [IdxW-1:0]                 count_q;
  logic [IdxW-1:0]                 sdist_q;
  logic                            acc_q;
  logic                            tx_q;
  logic [IdxW-1:0]                 tx_seq_q;
  logic [srsw_pkg::PAYLOAD_W-1:0]  tx_pay_q;
  logic                            t_stop_q;
  logic                            t_start_q;
  logic [IdxW-1:0]                 t_seq_q;

  logic            seq_in_space;
  logic [IdxW-1:0] seq_idx;
  logic            send_ok;
  logic            ack_ok;
  logic            tmo_ok;
  logic            full_after;

  // remainder by compare and subtract, one bit a step
  function automatic logic [IdxW-1:0] rem_f(input logic [IdxW-1:0] v,
                                            input logic [SpW-1:0] d);
    logic [SpW:0] r;
    r = '0;
    for (int i = IdxW - 1; i >= 0; i--) begin
      r = {r[SpW-1:0], v[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
    end
    return r[IdxW-1:0];
  endfunction

  always_comb begin
    seq_in_space = 32'(seq_q) < 32'(space_i);
    seq_idx      = IdxW'(seq_q);
    send_ok      = (cmd_q == srsw_pkg::CMD_SEND) && !waiting_q && (count_q < win_i);
    ack_ok       = (cmd_q == srsw_pkg::CMD_ACK) && chk_q && seq_in_space &&
                   (sdist_q < count_q) && !mark_seq_i;
    tmo_ok       = (cmd_q == srsw_pkg::CMD_TIMEOUT) && seq_in_space && (sdist_q < count_q);
    full_after   = ({1'b0, count_q} + {{IdxW{1'b0}}, 1'b1}) >= {1'b0, win_i};

    case (state_q)
      ST_COUNT: begin
        unit_op_o = srsw_pkg::OP_DIST;
        unit_a_o  = next_q;
      end
      ST_SDIST: begin
        unit_op_o = srsw_pkg::OP_DIST;
        unit_a_o  = seq_idx;
      end
      ST_EXEC: begin
        unit_op_o = srsw_pkg::OP_INC;
        unit_a_o  = next_q;
      end
      ST_SLIDE: begin
        unit_op_o = srsw_pkg::OP_INC;
        unit_a_o  = base_q;
      end
      default: begin
        unit_op_o = srsw_pkg::OP_DIST;
        unit_a_o  = next_q;
      end
    endcase
    unit_b_o = base_q;

    mark_we_o  = ((state_q == ST_EXEC) && (send_ok || ack_ok)) ||
                 ((state_q == ST_SLIDE) && mark_base_i);
    mark_idx_o = (state_q == ST_EXEC) ? (send_ok ? next_q : seq_idx) : base_q;
    mark_val_o = (state_q == ST_EXEC) && (cmd_q == srsw_pkg::CMD_ACK);
    seq_idx_o  = seq_idx;
    base_idx_o = base_q;

    mem_we_o    = (state_q == ST_EXEC) && send_ok;
    mem_waddr_o = next_q;
    mem_wdata_o = payload_q;
    mem_re_o    = (state_q == ST_EXEC) && tmo_ok;
    mem_raddr_o = seq_idx;

    in_ready_o = (state_q == ST_IDLE);
    done_o     = (state_q == ST_FIN) && out_free_i;

    res_o.accepted    = acc_q;
    res_o.transmit    = tx_q;
    res_o.tx_seq      = SeqW'(tx_seq_q);
    res_o.tx_payload  = tx_pay_q;
    res_o.timer_stop  = t_stop_q;
    res_o.timer_start = t_start_q;
    res_o.timer_seq   = SeqW'(t_seq_q);
    res_o.window_full = waiting_q;
    res_o.window_base = SeqW'(base_q);
    res_o.next_seq    = SeqW'(next_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= '0;
      payload_q <= '0;
      seq_q     <= '0;
      chk_q     <= 1'b0;
      base_q    <= '0;
      next_q    <= '0;
      waiting_q <= 1'b0;
      count_q   <= '0;
      sdist_q   <= '0;
      acc_q     <= 1'b0;
      tx_q      <= 1'b0;
      tx_seq_q  <= '0;
      tx_pay_q  <= '0;
      t_stop_q  <= 1'b0;
      t_start_q <= 1'b0;
      t_seq_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= in_item_i.command;
            payload_q <= in_item_i.payload;
            seq_q     <= in_item_i.seq_num;
            chk_q     <= in_item_i.ack_check_ok;
            acc_q     <= 1'b0;
            tx_q      <= 1'b0;
            tx_seq_q  <= '0;
            tx_pay_q  <= '0;
            t_stop_q  <= 1'b0;
            t_start_q <= 1'b0;
            t_seq_q   <= '0;
            state_q   <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          count_q <= unit_res_i;
          state_q <= (cmd_q == srsw_pkg::CMD_SEND) ? ST_EXEC : ST_SDIST;
        end
        ST_SDIST: begin
          sdist_q <= unit_res_i;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          case (cmd_q)
            srsw_pkg::CMD_SEND: begin
              state_q <= ST_FIN;
              if (send_ok) begin
                acc_q     <= 1'b1;
                tx_q      <= 1'b1;
                tx_seq_q  <= next_q;
                tx_pay_q  <= payload_q;
                t_start_q <= 1'b1;
                t_seq_q   <= next_q;
                next_q    <= unit_res_i;
                waiting_q <= full_after;
              end
            end
            srsw_pkg::CMD_ACK: begin
              if (ack_ok) begin
                t_stop_q <= 1'b1;
                t_seq_q  <= seq_idx;
                state_q  <= ST_SLIDE;
              end else begin
                state_q <= ST_FIN;
              end
            end
            srsw_pkg::CMD_TIMEOUT: begin
              if (tmo_ok) begin
                tx_q      <= 1'b1;
                tx_seq_q  <= seq_idx;
                t_stop_q  <= 1'b1;
                t_start_q <= 1'b1;
                t_seq_q   <= seq_idx;
                state_q   <= ST_READ;
              end else begin
                state_q <= ST_FIN;
              end
            end
            default: begin
              state_q <= ST_FIN;
            end
          endcase
        end
        ST_SLIDE: begin
          // one marked number slid over per cycle
          if (mark_base_i) begin
            base_q    <= unit_res_i;
            waiting_q <= 1'b0;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_READ: begin
          tx_pay_q <= mem_rdata_i;
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_space_we_i) begin
        base_q <= rem_f(base_q, cfg_space_i);
        next_q <= rem_f(next_q, cfg_space_i);
      end
    end
  end

  a_window_in_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, base_q} < space_i) && ({1'b0, next_q} < space_i))
    else $error("window pointer at or above sequence space");

  a_send_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && send_ok && !cfg_space_we_i) |=> (next_q != $past(next_q)))
    else $error("accepted send did not advance next number");

  a_full_clears_on_slide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(waiting_q) |-> ($past(state_q) == ST_SLIDE))
    else $error("window full cleared outside a slide");

  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(mem_re_o))
    else $error("resend without a payload read");

endmodule

`default_nettype wire

// ===== sv/selective_repeat_sender_window_core.sv =====
// top level of the selective-repeat sender window
`default_nettype none

// Sender side of a selective-repeat ARQ scheme. Each transfer on the input
// channel carries one command (send, ack arrived, timer expired) and gives
// exactly one result transfer with the transmit, timer and window status.
// The block works on one item at a time and is not ready meanwhile; a
// finished result waits in an output register, so the next item is taken
// while it is still pending. Each item steps through a count of the
// outstanding numbers, for an ack or timeout the distance of its number
// from the base, the execute step, then the slide over marked numbers for
// a taken ack or the payload read for a resend, and the result hand-off.
// The shared modular unit does one distance or wrapping increment per
// cycle, the slide walks one mark per cycle, and the payload memory has a
// registered read port, used on a resend. Configuration writes take
// effect at once, and a sequence-space write reduces the window pointers
// to the new sequence space; they belong to times when the block is idle.
// There is no clearing pass after reset: marks live in flip-flops and the
// payload store is only read at numbers that have been sent.
module selective_repeat_sender_window_core #(
  parameter int MaxSeqSpace = srsw_pkg::DEF_MAX_SEQ_SPACE
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // command channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire srsw_pkg::in_item_t            in_item_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output srsw_pkg::out_item_t                out_item_o,
  // register write port
  input  wire                                cfg_we_i,
  input  wire [srsw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [srsw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int IdxW = $clog2(MaxSeqSpace);
  localparam int SpW  = IdxW + 1;

  // configuration registers, raw as written
  logic [srsw_pkg::SPACE_REG_W-1:0] seq_space_q;
  logic [srsw_pkg::WIN_REG_W-1:0]   window_q;

  // effective values after clamping
  logic [SpW-1:0]  space;
  logic [IdxW-1:0] win;
  logic            cfg_space_we;
  logic [SpW-1:0]  cfg_space;

  // result register between the sequencer and the output channel
  logic                out_valid_q;
  srsw_pkg::out_item_t out_item_q;
  logic                out_free;

  // sequencer to shared unit and store
  srsw_pkg::out_item_t            res;
  logic                           done;
  srsw_pkg::op_e                  unit_op;
  logic [IdxW-1:0]                unit_a;
  logic [IdxW-1:0]                unit_b;
  logic [IdxW-1:0]                unit_res;
  logic                           mark_we;
  logic [IdxW-1:0]                mark_idx;
  logic                           mark_val;
  logic [IdxW-1:0]                seq_idx;
  logic [IdxW-1:0]                base_idx;
  logic                           mark_seq;
  logic                           mark_base;
  logic                           mem_we;
  logic [IdxW-1:0]                mem_waddr;
  logic [srsw_pkg::PAYLOAD_W-1:0] mem_wdata;
  logic                           mem_re;
  logic [IdxW-1:0]                mem_raddr;
  logic [srsw_pkg::PAYLOAD_W-1:0] mem_rdata;

  // sequence space clamped to [2, MaxSeqSpace]
  function automatic logic [SpW-1:0] clamp_space(
      input logic [srsw_pkg::SPACE_REG_W-1:0] raw);
    logic [31:0] s;
    s = 32'(raw);
    if (s < 32'd2) begin
      s = 32'd2;
    end else if (s > 32'(MaxSeqSpace)) begin
      s = 32'(MaxSeqSpace);
    end
    return SpW'(s);
  endfunction

  always_comb begin
    logic [31:0] w;
    space = clamp_space(seq_space_q);
    // window clamped to [1, space - 1]
    w = 32'(window_q);
    if (w < 32'd1) begin
      w = 32'd1;
    end
    if (w > 32'(space) - 32'd1) begin
      w = 32'(space) - 32'd1;
    end
    win = IdxW'(w);
    cfg_space_we = cfg_we_i && (cfg_idx_i == srsw_pkg::REG_SEQ_SPACE);
    cfg_space    = clamp_space(cfg_wdata_i[srsw_pkg::SPACE_REG_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_space_q <= srsw_pkg::SEQ_SPACE_RST;
      window_q    <= srsw_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srsw_pkg::REG_SEQ_SPACE: begin
          seq_space_q <= cfg_wdata_i[srsw_pkg::SPACE_REG_W-1:0];
        end
        srsw_pkg::REG_WINDOW_SIZE: begin
          window_q <= cfg_wdata_i[srsw_pkg::WIN_REG_W-1:0];
        end
        default: begin
          window_q <= window_q;
        end
      endcase
    end
  end

  // output register: a new result is loaded when the slot is empty or
  // being taken in the same cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  srsw_ctrl #(
    .MaxSeqSpace (MaxSeqSpace)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .space_i        (space),
    .win_i          (win),
    .cfg_space_we_i (cfg_space_we),
    .cfg_space_i    (cfg_space),
    .out_free_i     (out_free),
    .done_o         (done),
    .res_o          (res),
    .unit_op_o      (unit_op),
    .unit_a_o       (unit_a),
    .unit_b_o       (unit_b),
    .unit_res_i     (unit_res),
    .mark_we_o      (mark_we),
    .mark_idx_o     (mark_idx),
    .mark_val_o     (mark_val),
    .seq_idx_o      (seq_idx),
    .base_idx_o     (base_idx),
    .mark_seq_i     (mark_seq),
    .mark_base_i    (mark_base),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // one modular unit shared by the count, distance, execute and slide steps of the sequencer
  srsw_modu #(
    .MaxSeqSpace (MaxSeqSpace)
  ) u_modu (
    .op_i    (unit_op),
    .a_i     (unit_a),
    .b_i     (unit_b),
    .space_i (space),
    .res_o   (unit_res)
  );

  srsw_store #(
    .MaxSeqSpace (MaxSeqSpace)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mark_we_i   (mark_we),
    .mark_idx_i  (mark_idx),
    .mark_val_i  (mark_val),
    .seq_idx_i   (seq_idx),
    .base_idx_i  (base_idx),
    .mark_seq_o  (mark_seq),
    .mark_base_o (mark_base),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .mem_re_i    (mem_re),
    .mem_raddr_i (mem_raddr),
    .mem_rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== sim/selective_repeat_sender_window_core_tb.sv =====
// self-checking testbench for the selective-repeat sender window core
module selective_repeat_sender_window_core_tb;

  localparam int MaxSeq     = srsw_pkg::DEF_MAX_SEQ_SPACE;
  localparam int SeqW       = srsw_pkg::SEQ_W;
  localparam int PayW       = srsw_pkg::PAYLOAD_W;
  localparam int CmdW       = srsw_pkg::CMD_W;
  localparam int CfgIdxW    = srsw_pkg::CFG_IDX_W;
  localparam int CfgDataW   = srsw_pkg::CFG_DATA_W;
  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 75;
  localparam int HoldCycles = 80;
  // the command code that the block must ignore
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  // tracks the sender window from the accepted commands and holds the
  // results that the block owes, oldest first
  class arq_window_tracker;
    logic [srsw_pkg::SPACE_REG_W-1:0] space_reg;
    logic [srsw_pkg::WIN_REG_W-1:0]   win_reg;
    int                               base;
    int                               nxt;
    bit                               full;
    bit                               marks[MaxSeq];
    bit                               written[MaxSeq];
    logic [PayW-1:0]                  store[MaxSeq];
    srsw_pkg::out_item_t              expected_results[$];
    int mismatches, results_seen, sends_ok, sends_refused;
    int acks_taken, resends, ignored, reg_writes;

    function new();
      space_reg = srsw_pkg::SEQ_SPACE_RST;
      win_reg   = srsw_pkg::WINDOW_RST;
      base = 0;
      nxt  = 0;
      full = 0;
      foreach (marks[i]) begin
        marks[i]   = 0;
        written[i] = 0;
        store[i]   = '0;
      end
    endfunction

    // effective wrap modulus after clamping
    function int space();
      int s;
      s = int'(space_reg);
      if (s < 2) s = 2;
      if (s > MaxSeq) s = MaxSeq;
      return s;
    endfunction

    // effective window after clamping to the sequence space
    function int window();
      int w, sp;
      sp = space();
      w  = int'(win_reg);
      if (w < 1) w = 1;
      if (w > sp - 1) w = sp - 1;
      return w;
    endfunction

    function int offset_of(int v);
      int sp;
      sp = space();
      return (v % sp + sp - base % sp) % sp;
    endfunction

    function int outstanding();
      return offset_of(nxt);
    endfunction

    function bit in_win(int s);
      if (s >= space()) return 0;
      return offset_of(s) < offset_of(nxt);
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == srsw_pkg::REG_SEQ_SPACE) space_reg = val;
      else win_reg = val[srsw_pkg::WIN_REG_W-1:0];
      // pointers fold into the new space, marks stay
      base = base % space();
      nxt  = nxt % space();
      reg_writes++;
    endfunction

    function void note_command(srsw_pkg::in_item_t it);
      srsw_pkg::out_item_t want;
      int sp, win, n, s, steps;
      sp    = space();
      win   = window();
      s     = int'(it.seq_num);
      steps = 0;
      want  = '0;
      case (it.command)
        srsw_pkg::CMD_SEND: begin
          if (!full && outstanding() < win) begin
            n = nxt % sp;
            store[n]   = it.payload;
            written[n] = 1;
            marks[n]   = 0;
            want.accepted    = 1'b1;
            want.transmit    = 1'b1;
            want.tx_seq      = SeqW'(n);
            want.tx_payload  = it.payload;
            want.timer_start = 1'b1;
            want.timer_seq   = SeqW'(n);
            nxt = (n + 1) % sp;
            if (outstanding() >= win) full = 1;
            sends_ok++;
          end else begin
            sends_refused++;
          end
        end
        srsw_pkg::CMD_ACK: begin
          if (it.ack_check_ok && in_win(s) && !marks[s]) begin
            marks[s] = 1;
            want.timer_stop = 1'b1;
            want.timer_seq  = SeqW'(s);
            // slide the base over consecutive marks
            while (steps < MaxSeq && marks[base % sp]) begin
              marks[base % sp] = 0;
              base = (base % sp + 1) % sp;
              full = 0;
              steps++;
            end
            acks_taken++;
          end else begin
            ignored++;
          end
        end
        srsw_pkg::CMD_TIMEOUT: begin
          if (in_win(s)) begin
            want.transmit    = 1'b1;
            want.tx_seq      = SeqW'(s);
            want.tx_payload  = store[s];
            want.timer_stop  = 1'b1;
            want.timer_start = 1'b1;
            want.timer_seq   = SeqW'(s);
            resends++;
          end else begin
            ignored++;
          end
        end
        default: ignored++;
      endcase
      want.window_full = full;
      want.window_base = SeqW'(base);
      want.next_seq    = SeqW'(nxt);
      expected_results = {expected_results, want};
    endfunction

    function void compare(string field, logic [PayW-1:0] want,
                          logic [PayW-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s of result %0d: expected %h, got %h",
                   field, results_seen, want, got);
      end
    endfunction

    function void check_result(srsw_pkg::out_item_t got);
      srsw_pkg::out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %p", results_seen, got);
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      compare("accepted", PayW'(want.accepted), PayW'(got.accepted));
      compare("transmit", PayW'(want.transmit), PayW'(got.transmit));
      compare("tx_seq", PayW'(want.tx_seq), PayW'(got.tx_seq));
      compare("tx_payload", want.tx_payload, got.tx_payload);
      compare("timer_stop", PayW'(want.timer_stop), PayW'(got.timer_stop));
      compare("timer_start", PayW'(want.timer_start), PayW'(got.timer_start));
      compare("timer_seq", PayW'(want.timer_seq), PayW'(got.timer_seq));
      compare("window_full", PayW'(want.window_full), PayW'(got.window_full));
      compare("window_base", PayW'(want.window_base), PayW'(got.window_base));
      compare("next_seq", PayW'(want.next_seq), PayW'(got.next_seq));
    endfunction
  endclass

  // every input of the block starts at a known value
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  srsw_pkg::in_item_t    in_item     = '0;
  logic                  out_ready   = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx     = '0;
  logic [CfgDataW-1:0]   cfg_wdata   = '0;
  logic                  in_ready;
  logic                  out_valid;
  srsw_pkg::out_item_t   out_item;

  arq_window_tracker tracker = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 0;
  int hold_left     = 0;
  int cycles        = 0;
  int items_sent    = 0;

  selective_repeat_sender_window_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycles, tracker.expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver side: random stalls, or a long hold-off counted here so the
  // block backs up and stops taking new commands
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result transfers are checked at the edge that takes them
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) tracker.check_result(out_item);
  end

  function automatic srsw_pkg::in_item_t make_item(logic [CmdW-1:0] cmd,
                                                   logic [PayW-1:0] data,
                                                   logic [SeqW-1:0] seq, logic chk);
    srsw_pkg::in_item_t it;
    it.command      = cmd;
    it.payload      = data;
    it.seq_num      = seq;
    it.ack_check_ok = chk;
    return it;
  endfunction

  // mostly well-formed traffic: sends, acks of outstanding numbers and
  // timeouts of outstanding numbers, with some noise mixed in
  function automatic srsw_pkg::in_item_t pick_command();
    srsw_pkg::in_item_t it;
    int roll, sp, cnt;
    bit blocked;
    it = make_item(srsw_pkg::CMD_SEND, {$urandom, $urandom}, SeqW'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
    sp      = tracker.space();
    cnt     = tracker.outstanding();
    blocked = tracker.full || cnt >= tracker.window();
    roll    = $urandom_range(0, 99);
    // a full window mostly turns sends into acks so that it drains
    if (roll < 45 && blocked && $urandom_range(0, 3) != 0) roll = 50;
    if (roll < 45) begin
      it.command = srsw_pkg::CMD_SEND;
    end else if (roll < 80) begin
      it.command = srsw_pkg::CMD_ACK;
      if (cnt > 0 && $urandom_range(0, 9) < 8) begin
        it.seq_num      = SeqW'((tracker.base + $urandom_range(0, cnt - 1)) % sp);
        it.ack_check_ok = 1'b1;
      end
    end else if (roll < 95) begin
      it.command = srsw_pkg::CMD_TIMEOUT;
      if (cnt > 0 && $urandom_range(0, 9) < 8)
        it.seq_num = SeqW'((tracker.base + $urandom_range(0, cnt - 1)) % sp);
    end else begin
      it.command = CMD_UNUSED;
    end
    // never resend a number whose payload was never stored
    if (it.command == srsw_pkg::CMD_TIMEOUT && tracker.in_win(int'(it.seq_num)) &&
        !tracker.written[it.seq_num]) begin
      it.command      = srsw_pkg::CMD_ACK;
      it.ack_check_ok = 1'b0;
    end
    return it;
  endfunction

  // offer one command, after a random gap, and wait for its transfer;
  // called at a rising edge and returns at the edge that took the item
  task automatic push_item(srsw_pkg::in_item_t it);
    int gaps;
    gaps = 0;
    while (gaps < 40 && $urandom_range(0, 99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    tracker.note_command(it);
    items_sent++;
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // register writes only while the block is idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    wait_results();
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.configure(idx, val);
  endtask

  // acknowledge from the base until nothing is outstanding
  task automatic drain_window();
    int guard;
    guard = 0;
    while (tracker.base != tracker.nxt && guard < 2 * MaxSeq) begin
      push_item(make_item(srsw_pkg::CMD_ACK, {$urandom, $urandom}, SeqW'(tracker.base),
                          1'b1));
      guard++;
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 70; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 70; end
      default: begin send_idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  int phase_space[9] = '{16, 2, 31, 0, 17, 5, 1, 8, 12};
  int phase_win[9]   = '{15, 1, 0, 15, 9, 3, 4, 4, 7};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset settings: space 8, window 4
    set_idling(0);
    push_item(make_item(srsw_pkg::CMD_SEND, 64'h0, 4'd0, 1'b0));
    push_item(make_item(srsw_pkg::CMD_SEND, '1, 4'd15, 1'b1));
    push_item(make_item(srsw_pkg::CMD_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 4'd5, 1'b0));
    push_item(make_item(srsw_pkg::CMD_SEND, 64'h5555_5555_5555_5555, 4'd10, 1'b1));
    // window is full now, this send is refused
    push_item(make_item(srsw_pkg::CMD_SEND, 64'h1234_5678_9ABC_DEF0, 4'd0, 1'b1));
    push_item(make_item(srsw_pkg::CMD_TIMEOUT, '1, 4'd2, 1'b0));
    // timeouts outside the window and beyond the sequence space
    push_item(make_item(srsw_pkg::CMD_TIMEOUT, 64'h0, 4'd7, 1'b1));
    push_item(make_item(srsw_pkg::CMD_TIMEOUT, 64'h0, 4'd15, 1'b1));
    // bad checksum, number beyond the space, number outside the window
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd0, 1'b0));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd12, 1'b1));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd5, 1'b1));
    // out-of-order ack, then the same ack again
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd1, 1'b1));
    push_item(make_item(srsw_pkg::CMD_ACK, '1, 4'd1, 1'b1));
    // acked but not yet slid over: still resent
    push_item(make_item(srsw_pkg::CMD_TIMEOUT, 64'h0, 4'd1, 1'b0));
    // base slides over two marks and the window opens again
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd0, 1'b1));
    push_item(make_item(CMD_UNUSED, '1, 4'd15, 1'b1));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd2, 1'b1));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd3, 1'b1));

    // fold the pointers back to zero, then a wider window
    write_reg(srsw_pkg::REG_SEQ_SPACE, 5'd4);
    write_reg(srsw_pkg::REG_SEQ_SPACE, 5'd8);
    write_reg(srsw_pkg::REG_WINDOW_SIZE, 5'd7);
    for (int i = 0; i < 5; i++)
      push_item(make_item(srsw_pkg::CMD_SEND, {$urandom, $urandom}, 4'd0, 1'b0));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd1, 1'b1));
    // shrink the space with packets outstanding: the mark on 1 is left
    // behind at the next number, and the following send has to clear it
    write_reg(srsw_pkg::REG_SEQ_SPACE, 5'd4);
    push_item(make_item(srsw_pkg::CMD_SEND, 64'hFEDC_BA98_7654_3210, 4'd0, 1'b0));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd0, 1'b1));
    push_item(make_item(srsw_pkg::CMD_ACK, 64'h0, 4'd1, 1'b1));

    // random phases, each at its own register setting and idling mode
    for (int p = 0; p < 9; p++) begin
      set_idling(p % 4);
      drain_window();
      write_reg(srsw_pkg::REG_SEQ_SPACE, CfgDataW'(phase_space[p]));
      write_reg(srsw_pkg::REG_WINDOW_SIZE, CfgDataW'(phase_win[p]));
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 0 && n == 20) hold_req = 1;
        if (p == 0 && n == 50) wait_results();
        push_item(pick_command());
      end
    end

    wait_results();
    repeat (30) @(posedge clk_i);
    $display("%0d commands in %0d register writes; %0d sends taken, %0d refused",
             items_sent, tracker.reg_writes, tracker.sends_ok, tracker.sends_refused);
    $display("%0d acks taken, %0d resends, %0d ignored; %0d results checked",
             tracker.acks_taken, tracker.resends, tracker.ignored, tracker.results_seen);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", tracker.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
